// ----- hw/rtl/htab_pkg.sv -----
// Shared types, constants and codes of the linear-probing hash table.
package htab_pkg;

   // Field and register widths
   localparam int KEY_W     = 31;
   localparam int SIZE_W    = 9;
   localparam int STATUS_W  = 2;
   localparam int SLOT_W    = 8;
   localparam int WORD_W    = KEY_W + 1;
   localparam int DIV_CNT_W = $clog2(KEY_W);
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   // Default table depth and reset value of the size register
   localparam int DEF_DEPTH = 256;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

   // Register index of the size register
   localparam logic REG_TABLE_SIZE = 1'b0;

   // Operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STS_INSERTED = 2'd0,
      STS_FULL     = 2'd1,
      STS_FOUND    = 2'd2,
      STS_MISSING  = 2'd3
   } status_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_HOME,
      ST_PROBE
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic clear;
      logic load;
      logic div;
      logic home;
      logic probe;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic clear_last;
      logic div_last;
      logic hit;
      logic probe_last;
   } stat_type;

endpackage

// ----- hw/rtl/linear_probe_hash_table_core.sv -----
// Linear-probing hash table core: register port, controller, datapath and slot memory.
// An item (insert or search of a 31-bit key) is accepted when start is high and busy is
// low. It runs a bit-serial key-modulo-size remainder, reads the home slot, then probes
// one slot of the slot memory per cycle, up to the clamped table size. The result word
// appears on rsp_status and rsp_slot for exactly one cycle with rsp_valid high, in the
// cycle busy falls; the receiver cannot stall it. After reset the block runs a clearing
// pass over every slot of the slot memory with busy high; register writes are taken
// during it. Change table_size only while idle.
module linear_probe_hash_table_core #(
   parameter int TABLE_DEPTH = htab_pkg::DEF_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_operation,
   input  logic [htab_pkg::KEY_W-1:0]    req_key,
   output logic                          rsp_valid,
   output logic [htab_pkg::STATUS_W-1:0] rsp_status,
   output logic [htab_pkg::SLOT_W-1:0]   rsp_slot,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [htab_pkg::CSR_AW-1:0]   paddr,
   input  logic [htab_pkg::CSR_DW-1:0]   pwdata,
   output logic [htab_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);

   localparam int AW = $clog2(TABLE_DEPTH);

   htab_pkg::cmd_type                cmd;
   htab_pkg::stat_type               stat;
   logic [htab_pkg::SIZE_W-1:0]      table_size_ff, table_size_in;
   logic                             csr_index;
   logic                             csr_wr;
   logic                             ram_we;
   logic [AW-1:0]                    ram_waddr;
   logic [htab_pkg::WORD_W-1:0]      ram_wdata;
   logic [AW-1:0]                    ram_raddr;
   logic [htab_pkg::WORD_W-1:0]      ram_rdata;

   // Decode register writes
   assign pready    = 1'b1;
   assign csr_index = paddr[htab_pkg::CSR_AW-1];
   assign csr_wr    = psel && penable && pwrite && pready;

   always_comb begin
      table_size_in = table_size_ff;
      if (csr_wr && (csr_index == htab_pkg::REG_TABLE_SIZE)) begin
         table_size_in = pwdata[htab_pkg::SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= htab_pkg::SIZE_RESET;
      end else begin
         table_size_ff <= table_size_in;
      end
   end

   // Return the size register, zero elsewhere
   assign prdata = (csr_index == htab_pkg::REG_TABLE_SIZE) ?
                   htab_pkg::CSR_DW'(table_size_ff) : '0;

   htab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   htab_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .table_size    (table_size_ff),
      .req_operation (req_operation),
      .req_key       (req_key),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata),
      .rsp_status    (rsp_status),
      .rsp_slot      (rsp_slot)
   );

   htab_ram #(
      .WIDTH (htab_pkg::WORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // A result word shows only once the block is free again
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // An accepted word keeps the block busy on the next cycle
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // One result per word: the strobe drops again after each result
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // Misses always report slot zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_status == htab_pkg::STS_FULL) ||
                     (rsp_status == htab_pkg::STS_MISSING))) |-> (rsp_slot == '0))
      else $error("miss reported a nonzero slot");

endmodule

// ----- hw/rtl/htab_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module htab_ram #(
   parameter int WIDTH = htab_pkg::WORD_W,
   parameter int DEPTH = htab_pkg::DEF_DEPTH,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one entry, register the read word
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/htab_ctrl.sv -----
// Controller state machine: clearing pass, divide, home read and probe walk.
module htab_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output logic               rsp_valid,
   output htab_pkg::cmd_type  cmd,
   input  htab_pkg::stat_type stat
);

   htab_pkg::state_type state_ff, state_in;
   logic                valid_ff, valid_in;

   // Hold state and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= htab_pkg::ST_CLEAR;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      valid_in  = 1'b0;
      cmd       = '0;
      case (state_ff)
         htab_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = htab_pkg::ST_IDLE;
            end
         end
         htab_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = htab_pkg::ST_DIVIDE;
            end
         end
         htab_pkg::ST_DIVIDE: begin
            cmd.div = 1'b1;
            if (stat.div_last) begin
               state_in = htab_pkg::ST_HOME;
            end
         end
         htab_pkg::ST_HOME: begin
            cmd.home = 1'b1;
            state_in = htab_pkg::ST_PROBE;
         end
         htab_pkg::ST_PROBE: begin
            cmd.probe = 1'b1;
            if (stat.hit || stat.probe_last) begin
               valid_in = 1'b1;
               state_in = htab_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = htab_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != htab_pkg::ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

// ----- hw/rtl/htab_dpath.sv -----
// Datapath: size clamp, bit-serial remainder, probe pointer and result words.
module htab_dpath #(
   parameter int TABLE_DEPTH = htab_pkg::DEF_DEPTH,
   localparam int AW = $clog2(TABLE_DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  htab_pkg::cmd_type             cmd,
   output htab_pkg::stat_type            stat,
   input  logic [htab_pkg::SIZE_W-1:0]   table_size,
   input  logic                          req_operation,
   input  logic [htab_pkg::KEY_W-1:0]    req_key,
   output logic                          ram_we,
   output logic [AW-1:0]                 ram_waddr,
   output logic [htab_pkg::WORD_W-1:0]   ram_wdata,
   output logic [AW-1:0]                 ram_raddr,
   input  logic [htab_pkg::WORD_W-1:0]   ram_rdata,
   output logic [htab_pkg::STATUS_W-1:0] rsp_status,
   output logic [htab_pkg::SLOT_W-1:0]   rsp_slot
);

   localparam int SW = htab_pkg::SIZE_W;
   localparam int KW = htab_pkg::KEY_W;
   localparam int NW = (AW + 1 > SW) ? AW + 1 : SW;

   logic [NW-1:0]                    size_ext;
   logic [NW-1:0]                    depth_n;
   logic [NW-1:0]                    eff_n;
   logic [SW-1:0]                    div_n;
   logic [SW:0]                      trial;
   logic [SW:0]                      diff;
   logic [NW-1:0]                    rem_ext;
   logic [NW-1:0]                    pos_inc;
   logic [NW-1:0]                    pos_ext;
   logic [AW-1:0]                    pos_next;
   logic                             hit;
   logic                             done;

   logic [AW-1:0]                    clr_addr_ff, clr_addr_in;
   logic                             op_ff, op_in;
   logic [KW-1:0]                    key_ff, key_in;
   logic [KW-1:0]                    key_sh_ff, key_sh_in;
   logic [SW-1:0]                    rem_ff, rem_in;
   logic [htab_pkg::DIV_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [AW-1:0]                    pos_ff, pos_in;
   logic [NW-1:0]                    cnt_ff, cnt_in;
   logic [htab_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic [htab_pkg::SLOT_W-1:0]      slot_ff, slot_in;

   // Clamp the configured size to 1..TABLE_DEPTH
   assign size_ext = NW'(table_size);
   assign depth_n  = NW'(TABLE_DEPTH);
   assign eff_n    = (table_size == '0) ? NW'(1) :
                     ((size_ext > depth_n) ? depth_n : size_ext);
   assign div_n    = eff_n[SW-1:0];

   // One restoring remainder step per cycle
   assign trial = {rem_ff, key_sh_ff[KW-1]};
   assign diff  = trial - {1'b0, div_n};

   // Probe position helpers
   assign rem_ext  = NW'(rem_ff);
   assign pos_ext  = NW'(pos_ff);
   assign pos_inc  = pos_ext + NW'(1);
   assign pos_next = (pos_inc >= eff_n) ? '0 : pos_inc[AW-1:0];

   // Match test on the word read for the current position
   assign hit = (op_ff == htab_pkg::OP_INSERT) ?
                !ram_rdata[KW] :
                (ram_rdata[KW] && (ram_rdata[KW-1:0] == key_ff));
   assign done = hit || stat.probe_last;

   assign stat.clear_last = (clr_addr_ff == AW'(TABLE_DEPTH - 1));
   assign stat.div_last   = (bit_cnt_ff == htab_pkg::DIV_CNT_W'(KW - 1));
   assign stat.hit        = hit;
   assign stat.probe_last = (cnt_ff == eff_n - NW'(1));

   // Advance clear pointer from reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      key_sh_ff  <= key_sh_in;
      rem_ff     <= rem_in;
      bit_cnt_ff <= bit_cnt_in;
      pos_ff     <= pos_in;
      cnt_ff     <= cnt_in;
      status_ff  <= status_in;
      slot_ff    <= slot_in;
   end

   // Next values of the datapath registers
   always_comb begin
      clr_addr_in = clr_addr_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      key_sh_in   = key_sh_ff;
      rem_in      = rem_ff;
      bit_cnt_in  = bit_cnt_ff;
      pos_in      = pos_ff;
      cnt_in      = cnt_ff;
      status_in   = status_ff;
      slot_in     = slot_ff;

      if (cmd.clear) begin
         clr_addr_in = clr_addr_ff + AW'(1);
      end

      // Capture the word and start the remainder
      if (cmd.load) begin
         op_in      = req_operation;
         key_in     = req_key;
         key_sh_in  = req_key;
         rem_in     = '0;
         bit_cnt_in = '0;
      end

      // Shift in one key bit, subtract when possible
      if (cmd.div) begin
         key_sh_in  = {key_sh_ff[KW-2:0], 1'b0};
         rem_in     = (trial >= {1'b0, div_n}) ? diff[SW-1:0] : trial[SW-1:0];
         bit_cnt_in = bit_cnt_ff + htab_pkg::DIV_CNT_W'(1);
      end

      // Point at the home slot
      if (cmd.home) begin
         pos_in = rem_ext[AW-1:0];
         cnt_in = '0;
      end

      // Check one slot, then finish or step to the next
      if (cmd.probe) begin
         if (done) begin
            if (hit) begin
               status_in = (op_ff == htab_pkg::OP_INSERT) ?
                           htab_pkg::STS_INSERTED : htab_pkg::STS_FOUND;
               slot_in   = pos_ext[htab_pkg::SLOT_W-1:0];
            end else begin
               status_in = (op_ff == htab_pkg::OP_INSERT) ?
                           htab_pkg::STS_FULL : htab_pkg::STS_MISSING;
               slot_in   = '0;
            end
         end else begin
            pos_in = pos_next;
            cnt_in = cnt_ff + NW'(1);
         end
      end
   end

   // Memory port: clear sweep or insert write; read follows the next position
   assign ram_we    = cmd.clear || (cmd.probe && hit && (op_ff == htab_pkg::OP_INSERT));
   assign ram_waddr = cmd.clear ? clr_addr_ff : pos_ff;
   assign ram_wdata = cmd.clear ? '0 : {1'b1, key_ff};
   assign ram_raddr = pos_in;

   assign rsp_status = status_ff;
   assign rsp_slot   = slot_ff;

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench of the linear-probing hash table core.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int   DEPTH     = htab_pkg::DEF_DEPTH;
   localparam logic REG_SPARE = 1'b1;   // no register behind this index
   localparam logic CSR_WR    = 1'b1;
   localparam logic CSR_RD    = 1'b0;

   typedef struct {
      htab_pkg::status_type          status;
      logic [htab_pkg::SLOT_W-1:0]   slot;
   } probe_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic                          req_operation = htab_pkg::OP_INSERT;
   logic [htab_pkg::KEY_W-1:0]    req_key = '0;
   logic                          rsp_valid;
   logic [htab_pkg::STATUS_W-1:0] rsp_status;
   logic [htab_pkg::SLOT_W-1:0]   rsp_slot;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [htab_pkg::CSR_AW-1:0]   paddr = '0;
   logic [htab_pkg::CSR_DW-1:0]   pwdata = '0;
   logic [htab_pkg::CSR_DW-1:0]   prdata;
   logic                          pready;

   // Mirror of the table contents and the size register
   logic [htab_pkg::KEY_W-1:0]    slot_key_copy [DEPTH];
   logic                          slot_used_copy [DEPTH];
   logic [htab_pkg::SIZE_W-1:0]   size_copy;

   probe_result_type              pending_results [$];
   logic [htab_pkg::KEY_W-1:0]    stored_keys [$];
   int                            mismatch_count = 0;
   int                            burst_left = 0;
   bit                            gaps_on = 1'b1;

   linear_probe_hash_table_core dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_key       (req_key),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_slot      (rsp_slot),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Clamp the size register to the slots that exist
   function automatic int unsigned live_size(input logic [htab_pkg::SIZE_W-1:0] size_reg);
      int unsigned n;
      n = 32'(size_reg);
      if (n == 0) n = 1;
      if (n > DEPTH) n = DEPTH;
      return n;
   endfunction

   // Walk the table from the home slot and update the mirror on an insert
   function automatic probe_result_type probe_table(input logic op,
                                                    input logic [htab_pkg::KEY_W-1:0] key);
      probe_result_type res;
      int unsigned      n;
      int unsigned      pos;
      bit               done;
      n = live_size(size_copy);
      pos = 32'(key) % n;
      done = 1'b0;
      res.status = (op == htab_pkg::OP_INSERT) ? htab_pkg::STS_FULL : htab_pkg::STS_MISSING;
      res.slot = '0;
      for (int unsigned k = 0; k < n && !done; k++) begin
         if (op == htab_pkg::OP_INSERT) begin
            if (!slot_used_copy[pos]) begin
               slot_used_copy[pos] = 1'b1;
               slot_key_copy[pos] = key;
               res.status = htab_pkg::STS_INSERTED;
               res.slot = pos[htab_pkg::SLOT_W-1:0];
               done = 1'b1;
            end
         end else if (slot_used_copy[pos] && slot_key_copy[pos] == key) begin
            res.status = htab_pkg::STS_FOUND;
            res.slot = pos[htab_pkg::SLOT_W-1:0];
            done = 1'b1;
         end
         pos = (pos + 1 >= n) ? 0 : pos + 1;
      end
      return res;
   endfunction

   task automatic note_mismatch(input string what, input longint unsigned want,
                                input longint unsigned got);
      mismatch_count++;
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
   endtask

   // Compare each result word with the oldest expectation
   always @(posedge clock) begin
      probe_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: unexpected result word: expected none, actual status %0d slot %0d",
                     $time, rsp_status, rsp_slot);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               note_mismatch("status", 64'(want.status), 64'(rsp_status));
            if (rsp_slot !== want.slot)
               note_mismatch("slot", 64'(want.slot), 64'(rsp_slot));
         end
      end
   end

   // Send one request word, idling between bursts while gaps are on
   task automatic send_word(input logic op, input logic [htab_pkg::KEY_W-1:0] key);
      int unsigned      gap;
      probe_result_type res;
      if (burst_left == 0) begin
         burst_left = int'($urandom_range(1, 12));
         gap = gaps_on ? $urandom_range(1, 80) : 0;
         if (gap != 0) begin
            @(negedge clock);
            start = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      start = 1'b1;
      req_operation = op;
      req_key = key;
      @(posedge clock);
      while (busy) @(posedge clock);
      res = probe_table(op, key);
      if (res.status == htab_pkg::STS_INSERTED) stored_keys.push_back(key);
      pending_results.push_back(res);
   endtask

   // Drop start and hold until every expected word has come back
   task automatic drain_results();
      @(negedge clock);
      start = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // One register access: setup cycle, then access cycle
   task automatic csr_access(input logic idx, input logic wr,
                             input logic [htab_pkg::CSR_DW-1:0] wdata,
                             output logic [htab_pkg::CSR_DW-1:0] rdata);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = wr;
      paddr = {idx, 2'b00};
      pwdata = wdata;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      if (wr && idx == htab_pkg::REG_TABLE_SIZE) size_copy = wdata[htab_pkg::SIZE_W-1:0];
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic check_table_size();
      logic [htab_pkg::CSR_DW-1:0] rdata;
      csr_access(htab_pkg::REG_TABLE_SIZE, CSR_RD, '0, rdata);
      if (rdata !== {{(htab_pkg::CSR_DW - htab_pkg::SIZE_W){1'b0}}, size_copy})
         note_mismatch("table_size readback", 64'(size_copy), 64'(rdata));
   endtask

   // Write a register once the block is idle, then read the size back
   task automatic write_config(input logic idx, input logic [htab_pkg::CSR_DW-1:0] value);
      logic [htab_pkg::CSR_DW-1:0] rdata;
      drain_results();
      csr_access(idx, CSR_WR, value, rdata);
      check_table_size();
   endtask

   // Reset value, the spare index and masking of the upper data bits
   task automatic test_register_port();
      check_table_size();
      write_config(REG_SPARE, 32'd3);
      write_config(htab_pkg::REG_TABLE_SIZE, 32'hFFFF_FE05);
      write_config(htab_pkg::REG_TABLE_SIZE, 32'd256);
   endtask

   // Key extremes, collisions, wrap past the last slot, duplicates, hits and misses
   task automatic test_probe_basics();
      send_word(htab_pkg::OP_INSERT, 31'd0);
      send_word(htab_pkg::OP_INSERT, 31'h7FFF_FFFF);
      send_word(htab_pkg::OP_INSERT, 31'd256);
      send_word(htab_pkg::OP_INSERT, 31'd511);
      send_word(htab_pkg::OP_INSERT, 31'd0);
      send_word(htab_pkg::OP_SEARCH, 31'd0);
      send_word(htab_pkg::OP_SEARCH, 31'd511);
      send_word(htab_pkg::OP_SEARCH, 31'd1);
      send_word(htab_pkg::OP_SEARCH, 31'h7FFF_FFFF);
   endtask

   // Size zero acts as one, sizes past the depth act as the depth
   task automatic test_size_extremes();
      write_config(htab_pkg::REG_TABLE_SIZE, 32'd0);
      send_word(htab_pkg::OP_INSERT, 31'd5);
      send_word(htab_pkg::OP_SEARCH, 31'd0);
      send_word(htab_pkg::OP_SEARCH, 31'd256);
      write_config(htab_pkg::REG_TABLE_SIZE, 32'hFFFF_FFFF);
      send_word(htab_pkg::OP_SEARCH, 31'd511);
      send_word(htab_pkg::OP_INSERT, 31'h7FFF_FEFF);
   endtask

   // Shrink over filled slots, then grow so the hidden slots come back
   task automatic test_shrunk_table();
      write_config(htab_pkg::REG_TABLE_SIZE, 32'd3);
      send_word(htab_pkg::OP_INSERT, 31'd7);
      send_word(htab_pkg::OP_SEARCH, 31'h7FFF_FFFF);
      write_config(htab_pkg::REG_TABLE_SIZE, 32'd6);
      send_word(htab_pkg::OP_INSERT, 31'd10);
      send_word(htab_pkg::OP_INSERT, 31'd11);
      send_word(htab_pkg::OP_INSERT, 31'd17);
      write_config(htab_pkg::REG_TABLE_SIZE, 32'd256);
      send_word(htab_pkg::OP_SEARCH, 31'h7FFF_FFFF);
   endtask

   // Random inserts and searches over a growing table size
   task automatic test_random_fill();
      int unsigned                phase_sizes [11] = '{1, 2, 9, 17, 40, 64, 100, 150, 200,
                                                       256, 511};
      int unsigned                eff;
      int unsigned                choice;
      int unsigned                home;
      longint unsigned            mult;
      logic [31:0]                rnd;
      logic                       op;
      logic [htab_pkg::KEY_W-1:0] key;
      for (int p = 0; p < 11; p++) begin
         write_config(htab_pkg::REG_TABLE_SIZE, phase_sizes[p]);
         eff = live_size(htab_pkg::SIZE_W'(phase_sizes[p]));
         gaps_on = (p % 3) != 2;
         burst_left = 0;
         for (int i = 0; i < 110; i++) begin
            op = $urandom_range(0, 1) ? htab_pkg::OP_SEARCH : htab_pkg::OP_INSERT;
            choice = $urandom_range(0, 9);
            rnd = $urandom;
            key = rnd[htab_pkg::KEY_W-1:0];
            if (op == htab_pkg::OP_INSERT) begin
               if (choice >= 4 && choice < 6) begin
                  // aim at a chosen home slot
                  home = $urandom_range(0, eff - 1);
                  mult = 64'($urandom_range(0, (32'h7FFF_FFFF - eff) / eff));
                  key = htab_pkg::KEY_W'(mult * eff + home);
               end else if (choice >= 6 && choice < 8) begin
                  key = htab_pkg::KEY_W'($urandom_range(0, 600));
               end else if (choice >= 8 && stored_keys.size() != 0) begin
                  key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
               end
            end else if (stored_keys.size() != 0) begin
               if (choice < 6)
                  key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
               else if (choice == 8)
                  key = stored_keys[$urandom_range(0, stored_keys.size() - 1)] ^ 31'd1;
               else if (choice == 9)
                  key = htab_pkg::KEY_W'($urandom_range(0, 600));
            end
            send_word(op, key);
         end
      end
   endtask

   // Hard stop if the block hangs
   initial begin
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_used_copy[i] = 1'b0;
         slot_key_copy[i] = '0;
      end
      size_copy = htab_pkg::SIZE_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_register_port();
      test_probe_basics();
      test_size_extremes();
      test_shrunk_table();
      test_random_fill();

      // Let stray words show up before the verdict
      drain_results();
      repeat (300) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
